### sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define PLFG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define PLFG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### sv/plfg_pkg.sv
package plfg_pkg;

    localparam int FIELD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int POS_W     = 32;
    localparam int NODE_W    = 10;
    localparam int GSIZE_W   = 11;
    localparam int CFG_W     = 32;
    localparam int NUM_COMP  = 6;

    // Request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_GATHER = 1'b1;

    // Configuration register indexes
    localparam logic CFG_GRID_SIZE   = 1'b0;
    localparam logic CFG_INV_SPACING = 1'b1;

    // Six field components of one grid node
    typedef struct packed {
        logic signed [FIELD_W-1:0] b_x;
        logic signed [FIELD_W-1:0] b_y;
        logic signed [FIELD_W-1:0] b_z;
        logic signed [FIELD_W-1:0] e_x;
        logic signed [FIELD_W-1:0] e_y;
        logic signed [FIELD_W-1:0] e_z;
    } t_node;

    typedef logic [NUM_COMP-1:0][FIELD_W-1:0] t_comp_vec;

    // Load strobes for the interpolation lanes
    typedef struct packed {
        logic ld_diff;
        logic ld_prod;
    } t_lane_ctl;

endpackage

### sv/plfg_lerp.sv
module plfg_lerp
    import plfg_pkg::*;
(
    input  logic                      i_clk,
    input  t_lane_ctl                 i_ctl,
    input  logic signed [FIELD_W-1:0] i_lo,
    input  logic signed [FIELD_W-1:0] i_hi,
    input  logic [FRAC_W-1:0]         i_frac,
    output logic signed [FIELD_W-1:0] o_value
);

    logic signed [FIELD_W:0]               r_diff;
    logic signed [FIELD_W:0]               n_diff;
    logic signed [FIELD_W-1:0]             r_lo_d;
    logic signed [FIELD_W-1:0]             r_lo_p;
    logic signed [FIELD_W-1:0]             r_part;
    logic signed [FIELD_W-1:0]             n_part;
    logic signed [FIELD_W+FRAC_W+1:0]      prod_full;
    logic signed [FRAC_W:0]                frac_s;

    assign n_diff    = {i_hi[FIELD_W-1], i_hi} - {i_lo[FIELD_W-1], i_lo};
    assign frac_s    = {1'b0, i_frac};
    assign prod_full = r_diff * frac_s;
    // floor(d * frac / 2^16), kept to the field width
    assign n_part    = prod_full[FIELD_W+FRAC_W-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_diff) begin
            r_diff <= n_diff;
            r_lo_d <= i_lo;
        end
        if (i_ctl.ld_prod) begin
            r_part <= n_part;
            r_lo_p <= r_lo_d;
        end
    end

    assign o_value = r_lo_p + r_part;

endmodule

### sv/periodic_linear_field_gather_core.sv
// A gather result passes stage 1, memory read, difference, product and the
//   output register. One item (write or gather) per cycle unless the output
//   stalls; the node memory takes one write and two reads per cycle.
// Reset: clears the pipeline valids and loads grid_size 1024 (capped at the
//   memory depth) and inv_spacing 1.0; node memory is not cleared.
module periodic_linear_field_gather_core
    import plfg_pkg::*;
#(
    parameter int MAX_GRID_NODES = 1024
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_req_type,
    input  logic [NODE_W-1:0]         i_node_index,
    input  logic signed [FIELD_W-1:0] i_b_x_in,
    input  logic signed [FIELD_W-1:0] i_b_y_in,
    input  logic signed [FIELD_W-1:0] i_b_z_in,
    input  logic signed [FIELD_W-1:0] i_e_x_in,
    input  logic signed [FIELD_W-1:0] i_e_y_in,
    input  logic signed [FIELD_W-1:0] i_e_z_in,
    input  logic [POS_W-1:0]          i_position,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [NODE_W-1:0]         o_cell_index,
    output logic [FRAC_W-1:0]         o_fraction,
    output logic signed [FIELD_W-1:0] o_b_x_out,
    output logic signed [FIELD_W-1:0] o_b_y_out,
    output logic signed [FIELD_W-1:0] o_b_z_out,
    output logic signed [FIELD_W-1:0] o_e_x_out,
    output logic signed [FIELD_W-1:0] o_e_y_out,
    output logic signed [FIELD_W-1:0] o_e_z_out,
    output logic                      o_out_of_range
);

`include "assert_macros.svh"

    localparam int AW       = (MAX_GRID_NODES > 1) ? $clog2(MAX_GRID_NODES) : 1;
    localparam int SZW      = $clog2(MAX_GRID_NODES + 1);
    localparam int RST_SIZE = (MAX_GRID_NODES < 1024) ? MAX_GRID_NODES : 1024;
    localparam int PROD_W   = 2 * POS_W;

    // ------------------------------------------------------------------
    // Configuration: grid size is stored already capped at the memory depth
    // ------------------------------------------------------------------
    logic [SZW-1:0]   r_size;
    logic [SZW-1:0]   n_size;
    logic [CFG_W-1:0] r_inv_spacing;
    logic [GSIZE_W-1:0] cfg_gsize;

    assign cfg_gsize = i_cfg_wdata[GSIZE_W-1:0];

    always_comb begin
        if (32'(cfg_gsize) > 32'(MAX_GRID_NODES)) begin
            n_size = SZW'(MAX_GRID_NODES);
        end else begin
            n_size = SZW'(cfg_gsize);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size        <= SZW'(RST_SIZE);
            r_inv_spacing <= CFG_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_SIZE:   r_size        <= n_size;
                CFG_INV_SPACING: r_inv_spacing <= i_cfg_wdata;
                default:         r_inv_spacing <= r_inv_spacing;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage loads when it is empty or drains onward
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic ld_1, ld_2, ld_3, ld_4, ld_o;

    assign ld_o = !r_vo || i_out_ready;
    assign ld_4 = !r_v4 || ld_o;
    assign ld_3 = !r_v3 || ld_4;
    assign ld_2 = !r_v2 || ld_3;
    assign ld_1 = !r_v1 || ld_2;

    assign o_in_ready  = ld_1;
    assign o_out_valid = r_vo;

    // Stage 1: scale the position into a grid coordinate; hold write data
    logic               r_s1_gather;
    logic [NODE_W-1:0]  r_s1_node;
    t_node              r_s1_data;
    logic [PROD_W-1:0]  r_s1_coord;
    t_node              in_data;

    assign in_data = '{b_x: i_b_x_in, b_y: i_b_y_in, b_z: i_b_z_in,
                       e_x: i_e_x_in, e_y: i_e_y_in, e_z: i_e_z_in};

    always_ff @(posedge i_clk) begin
        if (ld_1) begin
            r_s1_gather <= (i_req_type == REQ_GATHER);
            r_s1_node   <= i_node_index;
            r_s1_data   <= in_data;
            r_s1_coord  <= PROD_W'(i_position) * PROD_W'(r_inv_spacing);
        end
    end

    // Cell, fraction, range check and the wrapped upper node
    logic [POS_W-1:0]  s1_cell;
    logic [FRAC_W-1:0] s1_frac;
    logic              s1_oor;
    logic [AW-1:0]     lo_addr;
    logic [AW-1:0]     hi_addr;
    logic [AW:0]       nxt_node;
    logic [AW-1:0]     wr_addr;
    logic              node_ok;
    logic              mem_we;

    assign s1_cell  = r_s1_coord[PROD_W-1:PROD_W-POS_W];
    assign s1_frac  = r_s1_coord[2*FRAC_W-1:FRAC_W];
    assign s1_oor   = (s1_cell >= 32'(r_size));
    assign lo_addr  = s1_cell[AW-1:0];
    assign nxt_node = {1'b0, lo_addr} + (AW+1)'(1);
    assign hi_addr  = (nxt_node == (AW+1)'(r_size)) ? '0 : nxt_node[AW-1:0];
    assign wr_addr  = AW'(r_s1_node);
    assign node_ok  = (32'(r_s1_node) < 32'(MAX_GRID_NODES));
    // Writes and reads both happen as the item leaves stage 1, in item order
    assign mem_we   = ld_2 && r_v1 && !r_s1_gather && node_ok;

    // ------------------------------------------------------------------
    // Node memory: one write port, two registered read ports
    // ------------------------------------------------------------------
    t_node r_mem [MAX_GRID_NODES];
    t_node r_rd_lo;
    t_node r_rd_hi;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_s1_data;
        end
        if (ld_2) begin
            r_rd_lo <= r_mem[lo_addr];
            r_rd_hi <= r_mem[hi_addr];
        end
    end

    // Stage 2..4 side info travels beside the lanes
    logic [NODE_W-1:0] r_s2_cell, r_s3_cell, r_s4_cell;
    logic [FRAC_W-1:0] r_s2_frac, r_s3_frac, r_s4_frac;
    logic              r_s2_oor,  r_s3_oor,  r_s4_oor;

    always_ff @(posedge i_clk) begin
        if (ld_2) begin
            r_s2_cell <= s1_cell[NODE_W-1:0];
            r_s2_frac <= s1_frac;
            r_s2_oor  <= s1_oor;
        end
        if (ld_3) begin
            r_s3_cell <= r_s2_cell;
            r_s3_frac <= r_s2_frac;
            r_s3_oor  <= r_s2_oor;
        end
        if (ld_4) begin
            r_s4_cell <= r_s3_cell;
            r_s4_frac <= r_s3_frac;
            r_s4_oor  <= r_s3_oor;
        end
    end

    // Valid chain; write items retire at stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (ld_1) r_v1 <= i_in_valid;
            if (ld_2) r_v2 <= r_v1 && r_s1_gather;
            if (ld_3) r_v3 <= r_v2;
            if (ld_4) r_v4 <= r_v3;
            if (ld_o) r_vo <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // Interpolation lanes: difference, weight multiply, add back
    // ------------------------------------------------------------------
    t_lane_ctl lane_ctl;
    t_comp_vec lo_vec;
    t_comp_vec hi_vec;
    t_comp_vec val_vec;

    assign lane_ctl = '{ld_diff: ld_3, ld_prod: ld_4};
    assign lo_vec   = r_rd_lo;
    assign hi_vec   = r_rd_hi;

    for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
        plfg_lerp u_lerp (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_lo    (lo_vec[g]),
            .i_hi    (hi_vec[g]),
            .i_frac  (r_s3_frac),
            .o_value (val_vec[g])
        );
    end

    // ------------------------------------------------------------------
    // Output register: zero every field of an out-of-range item
    // ------------------------------------------------------------------
    logic [NODE_W-1:0] r_out_cell;
    logic [FRAC_W-1:0] r_out_frac;
    logic              r_out_oor;
    t_node             r_out_fields;

    always_ff @(posedge i_clk) begin
        if (ld_o) begin
            r_out_oor <= r_s4_oor;
            if (r_s4_oor) begin
                r_out_cell   <= '0;
                r_out_frac   <= '0;
                r_out_fields <= '0;
            end else begin
                r_out_cell   <= r_s4_cell;
                r_out_frac   <= r_s4_frac;
                r_out_fields <= t_node'(val_vec);
            end
        end
    end

    assign o_cell_index   = r_out_cell;
    assign o_fraction     = r_out_frac;
    assign o_out_of_range = r_out_oor;
    assign o_b_x_out      = r_out_fields.b_x;
    assign o_b_y_out      = r_out_fields.b_y;
    assign o_b_z_out      = r_out_fields.b_z;
    assign o_e_x_out      = r_out_fields.e_x;
    assign o_e_y_out      = r_out_fields.e_y;
    assign o_e_z_out      = r_out_fields.e_z;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PLFG_ASSERT(a_stall_only_when_full,
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_vo),
        "input stalled with a free pipeline stage")
    `PLFG_ASSERT(a_oor_zero_fields,
        (o_out_valid && o_out_of_range) |-> (o_cell_index == '0 && o_fraction == '0
            && o_b_x_out == '0 && o_e_z_out == '0),
        "out-of-range result carries nonzero fields")
    `PLFG_ASSERT(a_read_stage_from_gather,
        (r_v2 && $past(ld_2)) |-> $past(r_v1 && r_s1_gather),
        "read stage holds an item that was not a gather")
    `PLFG_ASSERT_ALWAYS(a_no_result_after_reset,
        $past(!i_rst_n) |-> !o_out_valid,
        "result valid right after reset")

endmodule
